FILE: hw/rtl/bta_pkg.sv
// package: shared types, constants and helper functions of the radix converter
`timescale 1ns / 1ps
package bta_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int CHAR_W         = 7;
  localparam int COUNT_W        = 5;
  localparam int MODE_W         = 2;
  localparam int NIBBLE_W       = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;

  localparam logic [MODE_W-1:0] MODE_DEC = 2'd0;

  // digits needed for the largest decimal value of vb bits
  function automatic int dec_digits(input int vb);
    return ((vb * 1233) >> 12) + 1;
  endfunction

  function automatic int hex_digits(input int vb);
    return (vb + 3) / 4;
  endfunction

  function automatic int num_digits(input int vb);
    return (dec_digits(vb) > hex_digits(vb)) ? dec_digits(vb) : hex_digits(vb);
  endfunction

  function automatic logic [CHAR_W-1:0] to_char(input logic [NIBBLE_W-1:0] d,
                                                input logic upper);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-NIBBLE_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + d_ext;
    end else if (upper) begin
      return CHAR_UPPER_A + d_ext - 7'd10;
    end else begin
      return CHAR_LOWER_A + d_ext - 7'd10;
    end
  endfunction

  typedef struct packed {
    logic load;
    logic conv;
    logic norm;
    logic emit;
  } bta_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic remain_one;
    logic out_free;
  } bta_status_t;

endpackage

FILE: hw/rtl/binary_to_ascii_radix.sv
// top level: binary to ascii decimal / hex converter
`timescale 1ns / 1ps
// Converts one unsigned VALUE_BITS-bit number per item into its ASCII digits,
// most significant first, without leading zeros (zero gives a single '0').
// radix_mode 0 is decimal, 1 lowercase hex, 2 and 3 uppercase hex. One item
// takes a load, VALUE_BITS double dabble shift steps, one step per stripped
// leading zero digit, one step that finds the first nonzero digit and one
// step per digit out, which waits while the output is stalled (N = 20 digit
// slots at 64 bits, stripped plus emitted always N); the bit-serial shift
// loop sets most of the time per item.
// A new item is taken once the last digit of the previous one is loaded into
// the output register.
module binary_to_ascii_radix
  import bta_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        value,
  input  logic [MODE_W-1:0]  radix_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  digit_char,
  output logic [COUNT_W-1:0] digit_count,
  output logic               is_last
);

  bta_cmd_t    cmd;
  bta_status_t status;

  bta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bta_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .radix_mode  (radix_mode),
    .cmd         (cmd),
    .status      (status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .digit_char  (digit_char),
    .digit_count (digit_count),
    .is_last     (is_last)
  );

endmodule

FILE: hw/rtl/bta_ctrl.sv
// controller: sequences load, conversion, leading-zero strip and digit output
`timescale 1ns / 1ps
module bta_ctrl
  import bta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  bta_status_t status,
  output bta_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_NORM = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_last) begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (status.top_zero && !status.remain_one) begin
          cmd.norm = 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.remain_one) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/bta_datapath.sv
// datapath: double dabble shifter, digit register and output register
`timescale 1ns / 1ps
module bta_datapath
  import bta_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         value,
  input  logic [MODE_W-1:0]   radix_mode,
  input  bta_cmd_t            cmd,
  output bta_status_t         status,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [CHAR_W-1:0]   digit_char,
  output logic [COUNT_W-1:0]  digit_count,
  output logic                is_last
);

  localparam int NDIG   = num_digits(VALUE_BITS);
  localparam int DIG_W  = NDIG * NIBBLE_W;
  localparam int BIT_CW = $clog2(VALUE_BITS + 1);
  localparam int REM_W  = $clog2(NDIG + 1);

  logic [VALUE_BITS-1:0] val;
  logic [DIG_W-1:0]      digits;
  logic [DIG_W-1:0]      digits_adj;
  logic [BIT_CW-1:0]     bit_cnt;
  logic [REM_W-1:0]      remain;
  logic [REM_W-1:0]      total;
  logic                  dec;
  logic                  upper;
  logic [NIBBLE_W-1:0]   top_nib;

  assign top_nib = digits[DIG_W-1 -: NIBBLE_W];

  // add 3 to every decimal digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (dec && digits[i*NIBBLE_W +: NIBBLE_W] >= 4'd5) begin
        digits_adj[i*NIBBLE_W +: NIBBLE_W] = digits[i*NIBBLE_W +: NIBBLE_W] + 4'd3;
      end else begin
        digits_adj[i*NIBBLE_W +: NIBBLE_W] = digits[i*NIBBLE_W +: NIBBLE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val     <= value[VALUE_BITS-1:0];
      digits  <= '0;
      bit_cnt <= BIT_CW'(VALUE_BITS);
      remain  <= REM_W'(NDIG);
      dec     <= (radix_mode == MODE_DEC);
      upper   <= radix_mode[1];
    end else if (cmd.conv) begin
      digits  <= {digits_adj[DIG_W-2:0], val[VALUE_BITS-1]};
      val     <= {val[VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt - 1'b1;
    end else if (cmd.norm || cmd.emit) begin
      digits  <= {digits[DIG_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
      remain  <= remain - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digit_char  <= to_char(top_nib, upper);
      digit_count <= COUNT_W'(total);
      is_last     <= (remain == REM_W'(1));
    end
  end

  // digit count is taken when normalization ends, held for the whole number
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      total <= REM_W'(NDIG);
    end else if (cmd.norm) begin
      total <= total - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.conv_last  = (bit_cnt == BIT_CW'(1));
  assign status.top_zero   = (top_nib == '0);
  assign status.remain_one = (remain == REM_W'(1));
  assign status.out_free   = !out_valid || !out_stall;

endmodule
